// File: design/fth_pkg.sv
// ----------------------------------------------------------------------------
// fth_pkg
// Shared types and constants for the flow tuple hash pipeline.
// ----------------------------------------------------------------------------
package fth_pkg;

    localparam int unsigned WORD_W     = 32;
    localparam int unsigned PORT_W     = 16;
    localparam int unsigned WORD_COUNT = 9;

    typedef logic [WORD_W-1:0]                  t_word;
    typedef logic [PORT_W-1:0]                  t_port;
    typedef logic [WORD_COUNT-1:0][WORD_W-1:0]  t_word_list;

    // Hash constants
    localparam t_word MUL_WORD    = 32'd3266489917;
    localparam t_word MUL_ROUND   = 32'd668265263;
    localparam t_word MUL_FINAL_A = 32'd246822519;
    localparam t_word MUL_FINAL_B = 32'd3266489917;
    localparam t_word START_ADD   = 32'd374761393;
    localparam t_word HASH_SEED   = 32'd5197;
    localparam t_word HASH_LEN    = 32'd36;

    localparam int unsigned ROUND_ROT = 17;
    localparam int unsigned FIN_SH_A  = 15;
    localparam int unsigned FIN_SH_B  = 13;
    localparam int unsigned FIN_SH_C  = 16;

    localparam t_word ACC_START = t_word'(HASH_LEN + HASH_SEED + START_ADD);

endpackage

// File: design/fth_premul.sv
// ----------------------------------------------------------------------------
// fth_premul
// Takes the nine tuple words and multiplies each by the word constant.
// ----------------------------------------------------------------------------
module fth_premul (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  fth_pkg::t_word_list i_words,
    output logic                o_valid,
    input  logic                i_stall,
    output fth_pkg::t_word_list o_prods
);

    logic                r_v;
    logic                en;
    fth_pkg::t_word_list r_prods;
    fth_pkg::t_word_list n_prods;

    assign en      = ~r_v | ~i_stall;
    assign o_stall = ~en;

    always_comb begin
        for (int k = 0; k < fth_pkg::WORD_COUNT; k++) begin
            n_prods[k] = i_words[k] * fth_pkg::MUL_WORD;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (en) begin
            r_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_prods <= n_prods;
        end
    end

    assign o_valid = r_v;
    assign o_prods = r_prods;

endmodule

// File: design/fth_round.sv
// ----------------------------------------------------------------------------
// fth_round
// One accumulator round over two stages: add and rotate, then multiply.
// Consumes the lowest queued product and shifts the queue down.
// ----------------------------------------------------------------------------
module fth_round (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  fth_pkg::t_word      i_acc,
    input  fth_pkg::t_word_list i_prods,
    output logic                o_valid,
    input  logic                i_stall,
    output fth_pkg::t_word      o_acc,
    output fth_pkg::t_word_list o_prods
);

    logic                r_v1;
    logic                r_v2;
    logic                en1;
    logic                en2;
    fth_pkg::t_word      n_sum;
    fth_pkg::t_word      n_rot;
    fth_pkg::t_word      r_rot;
    fth_pkg::t_word      r_acc;
    fth_pkg::t_word_list r_rest1;
    fth_pkg::t_word_list r_rest2;

    assign en2     = ~r_v2 | ~i_stall;
    assign en1     = ~r_v1 | en2;
    assign o_stall = ~en1;

    assign n_sum = i_acc + i_prods[0];
    assign n_rot = {n_sum[fth_pkg::WORD_W-fth_pkg::ROUND_ROT-1:0],
                    n_sum[fth_pkg::WORD_W-1:fth_pkg::WORD_W-fth_pkg::ROUND_ROT]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            if (en1) begin
                r_v1 <= i_valid;
            end
            if (en2) begin
                r_v2 <= r_v1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en1) begin
            r_rot   <= n_rot;
            r_rest1 <= {fth_pkg::t_word'(0), i_prods[fth_pkg::WORD_COUNT-1:1]};
        end
        if (en2) begin
            r_acc   <= r_rot * fth_pkg::MUL_ROUND;
            r_rest2 <= r_rest1;
        end
    end

    assign o_valid = r_v2;
    assign o_acc   = r_acc;
    assign o_prods = r_rest2;

endmodule

// File: design/fth_final.sv
// ----------------------------------------------------------------------------
// fth_final
// Final avalanche over three stages: two xor-shift-multiply steps and a
// closing xor-shift.
// ----------------------------------------------------------------------------
module fth_final (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_stall,
    input  fth_pkg::t_word i_acc,
    output logic           o_valid,
    input  logic           i_stall,
    output fth_pkg::t_word o_hash
);

    logic           r_v1;
    logic           r_v2;
    logic           r_v3;
    logic           en1;
    logic           en2;
    logic           en3;
    fth_pkg::t_word n_x1;
    fth_pkg::t_word n_x2;
    fth_pkg::t_word r_m1;
    fth_pkg::t_word r_m2;
    fth_pkg::t_word r_hash;

    assign en3     = ~r_v3 | ~i_stall;
    assign en2     = ~r_v2 | en3;
    assign en1     = ~r_v1 | en2;
    assign o_stall = ~en1;

    assign n_x1 = i_acc ^ (i_acc >> fth_pkg::FIN_SH_A);
    assign n_x2 = r_m1 ^ (r_m1 >> fth_pkg::FIN_SH_B);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (en1) begin
                r_v1 <= i_valid;
            end
            if (en2) begin
                r_v2 <= r_v1;
            end
            if (en3) begin
                r_v3 <= r_v2;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en1) begin
            r_m1 <= n_x1 * fth_pkg::MUL_FINAL_A;
        end
        if (en2) begin
            r_m2 <= n_x2 * fth_pkg::MUL_FINAL_B;
        end
        if (en3) begin
            r_hash <= r_m2 ^ (r_m2 >> fth_pkg::FIN_SH_C);
        end
    end

    assign o_valid = r_v3;
    assign o_hash  = r_hash;

endmodule

// File: design/flow_tuple_hash.sv
// ----------------------------------------------------------------------------
// flow_tuple_hash
// Pipeline: 1 premultiply stage, 9 rounds of 2 stages each and 3 final
// stages between the accepted item and the result.
// Throughput: one item per cycle while the output is not stalled; each stage
// holds only while its item is stalled, so bubbles close up behind a stalled output.
// Reset: synchronous, active low; clears every stage valid, payload is kept.
// ----------------------------------------------------------------------------
module flow_tuple_hash (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // input channel
    input  logic                 i_valid,
    output logic                 o_stall,
    input  fth_pkg::t_word       i_src_word0,
    input  fth_pkg::t_word       i_src_word1,
    input  fth_pkg::t_word       i_src_word2,
    input  fth_pkg::t_word       i_src_word3,
    input  fth_pkg::t_word       i_dst_word0,
    input  fth_pkg::t_word       i_dst_word1,
    input  fth_pkg::t_word       i_dst_word2,
    input  fth_pkg::t_word       i_dst_word3,
    input  fth_pkg::t_port       i_src_port,
    input  fth_pkg::t_port       i_dst_port,
    // result channel
    output logic                 o_valid,
    input  logic                 i_stall,
    output fth_pkg::t_word       o_hash_value
);

    localparam int unsigned NW = fth_pkg::WORD_COUNT;

    fth_pkg::t_word_list words;

    // Handshake and payload between the chained sections; index 0 is the
    // premultiply output, index k+1 the output of round k.
    logic                v_chain [NW+1];
    logic                s_chain [NW+1];
    fth_pkg::t_word      a_chain [NW+1];
    fth_pkg::t_word_list p_chain [NW+1];

    // Assemble the tuple words in hashing order; the ninth word carries the
    // source port low and the destination port high.
    assign words[0] = i_src_word0;
    assign words[1] = i_src_word1;
    assign words[2] = i_src_word2;
    assign words[3] = i_src_word3;
    assign words[4] = i_dst_word0;
    assign words[5] = i_dst_word1;
    assign words[6] = i_dst_word2;
    assign words[7] = i_dst_word3;
    assign words[8] = {i_dst_port, i_src_port};

    // Every word product is independent of the accumulator: take them all
    // in the first stage.
    fth_premul u_premul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_words (words),
        .o_valid (v_chain[0]),
        .i_stall (s_chain[0]),
        .o_prods (p_chain[0])
    );

    // Seed the accumulator with the fixed start value.
    assign a_chain[0] = fth_pkg::ACC_START;

    // Advance the accumulator one word per round, oldest product first.
    for (genvar k = 0; k < NW; k++) begin : g_round
        fth_round u_round (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (v_chain[k]),
            .o_stall (s_chain[k]),
            .i_acc   (a_chain[k]),
            .i_prods (p_chain[k]),
            .o_valid (v_chain[k+1]),
            .i_stall (s_chain[k+1]),
            .o_acc   (a_chain[k+1]),
            .o_prods (p_chain[k+1])
        );
    end

    // Mix the final accumulator; the result register feeds the port.
    fth_final u_final (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (v_chain[NW]),
        .o_stall (s_chain[NW]),
        .i_acc   (a_chain[NW]),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_hash  (o_hash_value)
    );

endmodule

// File: verif/fth_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fth_checker
// Watches both channels of the flow tuple hash, computes the hash of every
// accepted tuple on its own and compares it with the results in order.
// ----------------------------------------------------------------------------
module fth_checker (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    input  logic            i_in_stall,
    input  fth_pkg::t_word  i_src_word0,
    input  fth_pkg::t_word  i_src_word1,
    input  fth_pkg::t_word  i_src_word2,
    input  fth_pkg::t_word  i_src_word3,
    input  fth_pkg::t_word  i_dst_word0,
    input  fth_pkg::t_word  i_dst_word1,
    input  fth_pkg::t_word  i_dst_word2,
    input  fth_pkg::t_word  i_dst_word3,
    input  fth_pkg::t_port  i_src_port,
    input  fth_pkg::t_port  i_dst_port,
    input  logic            i_out_valid,
    input  logic            i_out_stall,
    input  fth_pkg::t_word  i_hash_value,
    output int              o_fail_count,
    output int              o_pending,
    output int              o_checked
);

    localparam logic [31:0] K_WORD_MUL  = 32'd3266489917;
    localparam logic [31:0] K_ROUND_MUL = 32'd668265263;
    localparam logic [31:0] K_FIN_MUL_A = 32'd246822519;
    localparam logic [31:0] K_FIN_MUL_B = 32'd3266489917;
    localparam logic [31:0] K_SEED_SUM  = 32'd36 + 32'd5197 + 32'd374761393;

    // Ring of expected hashes; far deeper than the items the pipeline can hold
    fth_pkg::t_word expected_hashes [64];
    int             wr_count   = 0;
    int             rd_count   = 0;
    int             mismatches = 0;
    int             compared   = 0;

    function automatic fth_pkg::t_word tuple_hash(
        input fth_pkg::t_word s0, s1, s2, s3, d0, d1, d2, d3,
        input fth_pkg::t_port sp, dp
    );
        logic [31:0] words [9];
        logic [31:0] acc;
        logic [31:0] sum;
        int          k;
        words = '{s0, s1, s2, s3, d0, d1, d2, d3, {dp, sp}};
        acc   = K_SEED_SUM;
        for (k = 0; k < 9; k++) begin
            sum = acc + words[k] * K_WORD_MUL;
            acc = {sum[14:0], sum[31:15]} * K_ROUND_MUL;
        end
        acc = acc ^ (acc >> 15);
        acc = acc * K_FIN_MUL_A;
        acc = acc ^ (acc >> 13);
        acc = acc * K_FIN_MUL_B;
        acc = acc ^ (acc >> 16);
        return acc;
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_out_valid && !i_out_stall) begin
                if (rd_count == wr_count) begin
                    mismatches++;
                    $display("%0t: unexpected result, expected none, actual %08h",
                             $time, i_hash_value);
                end else begin
                    compared++;
                    if (expected_hashes[rd_count[5:0]] !== i_hash_value) begin
                        mismatches++;
                        $display("%0t: hash_value mismatch, expected %08h, actual %08h",
                                 $time, expected_hashes[rd_count[5:0]], i_hash_value);
                    end
                    rd_count++;
                end
            end
            if (i_in_valid && !i_in_stall) begin
                expected_hashes[wr_count[5:0]] = tuple_hash(
                    i_src_word0, i_src_word1, i_src_word2, i_src_word3,
                    i_dst_word0, i_dst_word1, i_dst_word2, i_dst_word3,
                    i_src_port, i_dst_port);
                wr_count++;
            end
        end
        o_fail_count <= mismatches;
        o_pending    <= wr_count - rd_count;
        o_checked    <= compared;
    end

endmodule

// File: verif/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives flow tuples into the hash pipeline: a directed set of extremes, then
// random tuples in bursts, against a receiver that stalls in varied patterns
// and once holds off long enough to back the pipeline up to its input.
// ----------------------------------------------------------------------------
module testbench;

    // Cycles without any handshake before the run is declared hung
    localparam int IDLE_LIMIT    = 2000;
    // Cycles to wait after the last result
    localparam int DRAIN_TAIL    = 40;
    localparam int RANDOM_ITEMS  = 1050;
    // Long receiver hold-off, started once this many items have gone in
    localparam int HOLD_CYCLES   = 400;
    localparam int HOLD_AFTER    = 300;

    typedef struct packed {
        fth_pkg::t_word [3:0] src;
        fth_pkg::t_word [3:0] dst;
        fth_pkg::t_port       sport;
        fth_pkg::t_port       dport;
    } t_flow_tuple;

    typedef enum int {STYLE_FULL, STYLE_SPARSE, STYLE_DENSE, STYLE_EDGE} t_fill_style;
    typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_BURSTY} t_stall_mode;

    logic           i_clk;
    logic           i_rst_n;
    logic           i_valid;
    logic           o_stall;
    fth_pkg::t_word i_src_word0, i_src_word1, i_src_word2, i_src_word3;
    fth_pkg::t_word i_dst_word0, i_dst_word1, i_dst_word2, i_dst_word3;
    fth_pkg::t_port i_src_port, i_dst_port;
    logic           o_valid;
    logic           i_stall;
    fth_pkg::t_word o_hash_value;

    int fail_count;
    int pending_hashes;
    int checked_hashes;
    int tuples_sent = 0;
    int idle_cycles = 0;
    bit hold_done   = 1'b0;

    flow_tuple_hash dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_src_word0  (i_src_word0),
        .i_src_word1  (i_src_word1),
        .i_src_word2  (i_src_word2),
        .i_src_word3  (i_src_word3),
        .i_dst_word0  (i_dst_word0),
        .i_dst_word1  (i_dst_word1),
        .i_dst_word2  (i_dst_word2),
        .i_dst_word3  (i_dst_word3),
        .i_src_port   (i_src_port),
        .i_dst_port   (i_dst_port),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_hash_value (o_hash_value)
    );

    fth_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_valid),
        .i_in_stall   (o_stall),
        .i_src_word0  (i_src_word0),
        .i_src_word1  (i_src_word1),
        .i_src_word2  (i_src_word2),
        .i_src_word3  (i_src_word3),
        .i_dst_word0  (i_dst_word0),
        .i_dst_word1  (i_dst_word1),
        .i_dst_word2  (i_dst_word2),
        .i_dst_word3  (i_dst_word3),
        .i_src_port   (i_src_port),
        .i_dst_port   (i_dst_port),
        .i_out_valid  (o_valid),
        .i_out_stall  (i_stall),
        .i_hash_value (o_hash_value),
        .o_fail_count (fail_count),
        .o_pending    (pending_hashes),
        .o_checked    (checked_hashes)
    );

    // Free-running clock, 2 ns period
    initial i_clk = 1'b0;
    always #1 i_clk = ~i_clk;

    // Present one tuple at a falling edge and hold it until the block takes
    // it; return at the following falling edge with valid still high.
    task automatic offer_tuple(input t_flow_tuple t);
        i_src_word0 <= t.src[0];
        i_src_word1 <= t.src[1];
        i_src_word2 <= t.src[2];
        i_src_word3 <= t.src[3];
        i_dst_word0 <= t.dst[0];
        i_dst_word1 <= t.dst[1];
        i_dst_word2 <= t.dst[2];
        i_dst_word3 <= t.dst[3];
        i_src_port  <= t.sport;
        i_dst_port  <= t.dport;
        i_valid     <= 1'b1;
        do @(posedge i_clk); while (o_stall);
        tuples_sent++;
        @(negedge i_clk);
    endtask

    // One random field value, shaped by the fill style of its tuple
    function automatic fth_pkg::t_word rand_word(input t_fill_style style);
        fth_pkg::t_word w;
        case (style)
            STYLE_SPARSE: w = $urandom & $urandom & $urandom;
            STYLE_DENSE:  w = $urandom | $urandom | $urandom;
            STYLE_EDGE: begin
                case ($urandom_range(0, 3))
                    0:       w = '0;
                    1:       w = '1;
                    2:       w = 32'h1 << $urandom_range(0, 31);
                    default: w = ~(32'h1 << $urandom_range(0, 31));
                endcase
            end
            default:      w = $urandom;
        endcase
        return w;
    endfunction

    // Main stimulus: reset, directed tuples, random bursts, drain, verdict
    initial begin
        t_flow_tuple t;
        t_fill_style style;
        int          burst_left;
        int          gap;
        int          n;
        int          f;

        // Hold every input at a known value from time zero
        i_rst_n     = 1'b0;
        i_valid     = 1'b0;
        i_src_word0 = '0;
        i_src_word1 = '0;
        i_src_word2 = '0;
        i_src_word3 = '0;
        i_dst_word0 = '0;
        i_dst_word1 = '0;
        i_dst_word2 = '0;
        i_dst_word3 = '0;
        i_src_port  = '0;
        i_dst_port  = '0;
        burst_left  = 0;

        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: all-zero and all-one tuples
        t = '0;
        offer_tuple(t);
        t = '1;
        offer_tuple(t);

        // Directed: drive each field to its maximum alone, ports included
        for (f = 0; f < 10; f++) begin
            t = '0;
            if (f < 4)
                t.src[f] = '1;
            else if (f < 8)
                t.dst[f-4] = '1;
            else if (f == 8)
                t.sport = '1;
            else
                t.dport = '1;
            offer_tuple(t);
        end

        // Directed: alternating bit patterns across the whole tuple
        t = {9{32'hAAAA_AAAA}};
        offer_tuple(t);
        t = {9{32'h5555_5555}};
        offer_tuple(t);

        // Directed: repeat earlier tuples; no state, so the hash must not move
        t = '0;
        offer_tuple(t);
        t = '1;
        offer_tuple(t);

        // Random tuples in bursts with random gaps between them
        for (n = 0; n < RANDOM_ITEMS; n++) begin
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 40);
                gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                if (gap != 0) begin
                    i_valid <= 1'b0;
                    repeat (gap) @(negedge i_clk);
                end
            end
            burst_left--;

            case ($urandom_range(0, 9))
                7:       style = STYLE_SPARSE;
                8:       style = STYLE_DENSE;
                9:       style = STYLE_EDGE;
                default: style = STYLE_FULL;
            endcase
            for (f = 0; f < 4; f++) begin
                t.src[f] = rand_word(style);
                t.dst[f] = rand_word(style);
            end
            t.sport = fth_pkg::t_port'(rand_word(style));
            t.dport = fth_pkg::t_port'(rand_word(style));
            offer_tuple(t);
        end
        i_valid <= 1'b0;

        // Drain: wait for every expected hash, then let the pipeline settle
        while (pending_hashes != 0) @(posedge i_clk);
        repeat (DRAIN_TAIL) @(posedge i_clk);

        $display("Sent %0d tuples (directed extremes, sparse/dense/edge/full random fills)",
                 tuples_sent);
        $display("Checked %0d hashes under bursty input, varied stalls and a %0d-cycle hold-off",
                 checked_hashes, HOLD_CYCLES);
        if (fail_count == 0)
            $display("flow_tuple_hash regression: pass");
        else
            $display("flow_tuple_hash regression: fail");
        $finish;
    end

    // Receiver: stall in segments of varied character; once, well into the
    // random part, hold off long enough for the pipeline to fill and push
    // back on its input.
    initial begin
        t_stall_mode mode;
        int          seg_len;

        i_stall = 1'b0;
        wait (i_rst_n);
        @(negedge i_clk);
        forever begin
            if (!hold_done && tuples_sent >= HOLD_AFTER) begin
                i_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                hold_done = 1'b1;
            end else begin
                mode    = t_stall_mode'($urandom_range(0, 3));
                seg_len = $urandom_range(20, 200);
                repeat (seg_len) begin
                    case (mode)
                        STALL_NONE:  i_stall <= 1'b0;
                        STALL_LIGHT: i_stall <= ($urandom_range(0, 7) == 0);
                        STALL_HEAVY: i_stall <= 1'($urandom_range(0, 1));
                        default: begin
                            // Flip the stall now and then to make runs of it
                            if ($urandom_range(0, 3) == 0)
                                i_stall <= ~i_stall;
                        end
                    endcase
                    @(negedge i_clk);
                end
            end
        end
    end

    // Watchdog: count cycles with no handshake on either channel
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("Timed out after %0d cycles with no handshake", IDLE_LIMIT);
            $display("flow_tuple_hash regression: fail");
            $finish;
        end
    end

endmodule

// File: files.f
design/fth_pkg.sv
design/fth_premul.sv
design/fth_round.sv
design/fth_final.sv
design/flow_tuple_hash.sv
verif/fth_checker.sv
verif/testbench.sv
